// ----- hw/rtl/sbsu_pkg.sv -----
// shared types and constants for the sensor byte stream unpacker
package sbsu_pkg;

	// stream tag codes
	localparam logic KIND_ACCEL   = 1'b0;
	localparam logic KIND_OPTICAL = 1'b1;

	// configuration register indexes
	localparam logic [0:0] REG_ACCEL_SCALE = 1'd0;
	localparam logic [0:0] REG_SPO2_MODE   = 1'd1;

	localparam int unsigned CFG_DATA_W = 16;

	// reset values of the configuration registers
	localparam logic [15:0] ACCEL_SCALE_RST = 16'd4096;
	localparam logic        SPO2_MODE_RST   = 1'b1;

	// group sizes in bytes
	localparam logic [1:0] ACCEL_GROUP    = 2'd3;
	localparam logic [2:0] OPT_GROUP_SPO2 = 3'd6;
	localparam logic [2:0] OPT_GROUP_IR   = 3'd3;

	localparam int unsigned OPT_HOLD = 5;

	typedef struct packed {
		logic        kind;
		logic [7:0]  data_byte;
		logic [31:0] time_ms;
	} src_word_t;

	typedef struct packed {
		logic               sample_kind;
		logic signed [23:0] accel_x;
		logic signed [23:0] accel_y;
		logic signed [23:0] accel_z;
		logic [23:0]        red_level;
		logic [23:0]        ir_level;
		logic               has_red;
		logic [31:0]        stamp_ms;
	} smp_word_t;

endpackage

// ----- hw/rtl/sbsu_scale.sv -----
// signed count times unsigned q4.12 scale, low 24 bits kept
module sbsu_scale
	import sbsu_pkg::*;
(
	input  logic [7:0]         raw,
	input  logic [15:0]        scale,
	output logic signed [23:0] scaled
);

	logic [23:0] raw_ext;
	logic [23:0] scale_ext;
	logic [23:0] prod;

	// sign extend the count, product wraps mod 2^24 which equals the signed result
	assign raw_ext   = {{16{raw[7]}}, raw};
	assign scale_ext = {8'd0, scale};
	assign prod      = raw_ext * scale_ext;
	assign scaled    = signed'(prod);

endmodule

// ----- hw/rtl/sensor_byte_stream_unpacker.sv -----
// top level of the sensor byte stream unpacker
//
// channel   direction  payload     handshake
// src       in         src_word_t  src_valid / src_stall
// smp       out        smp_word_t  smp_valid / smp_stall
// cfg       in         16b data    cfg_we / cfg_index, no wait
//
// one byte word per cycle while src_stall is low: a byte is registered in
// stage 1, then the group fill update and the three 24x24 scale multipliers
// run combinationally into the output register, which drives smp_valid.
// reset clears the fill counts and valid flags and loads scale 4096, spo2 on.
// stage 1 keeps taking words while a finished sample waits in the output
// register; a stalled sample blocks stage 1 only if its word completes a group.
module sensor_byte_stream_unpacker
	import sbsu_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [0:0]            cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  src_valid,
	output logic                  src_stall,
	input  src_word_t             src_word,
	output logic                  smp_valid,
	input  logic                  smp_stall,
	output smp_word_t             smp_word
);

	// configuration
	logic [15:0] accel_scale_q;
	logic        spo2_mode_q;

	// stage 1 input register
	logic        valid_s1;
	src_word_t   word_s1;

	// group assembly state
	logic [7:0]  accel_pend_q [2];
	logic [1:0]  accel_fill_q;
	logic [7:0]  opt_pend_q [OPT_HOLD];
	logic [2:0]  opt_fill_q;

	// output register
	logic        smp_valid_q;
	smp_word_t   smp_word_q;

	logic        accel_done;
	logic        opt_done;
	logic        produce;
	logic        adv_s1;
	logic [2:0]  opt_group;
	smp_word_t   result;
	logic signed [23:0] ax, ay, az;

	// register writes, only the register's width is kept
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			accel_scale_q <= ACCEL_SCALE_RST;
			spo2_mode_q   <= SPO2_MODE_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_ACCEL_SCALE: accel_scale_q <= cfg_data[15:0];
				REG_SPO2_MODE:   spo2_mode_q   <= cfg_data[0];
			endcase
		end
	end

	// completion checks for the word in stage 1
	assign opt_group  = spo2_mode_q ? OPT_GROUP_SPO2 : OPT_GROUP_IR;
	assign accel_done = (word_s1.kind == KIND_ACCEL) && (accel_fill_q == ACCEL_GROUP - 2'd1);
	// a mode change can leave more bytes held than the group needs
	assign opt_done   = (word_s1.kind == KIND_OPTICAL) && ((opt_fill_q + 3'd1) >= opt_group);
	assign produce    = accel_done || opt_done;

	// stage 1 moves on unless it makes a sample and the output is blocked
	assign adv_s1    = valid_s1 && (!produce || !smp_valid_q || !smp_stall);
	assign src_stall = valid_s1 && !adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (src_valid && !src_stall) begin
			valid_s1 <= 1'b1;
		end else if (adv_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (src_valid && !src_stall) begin
			word_s1 <= src_word;
		end
	end

	// per-axis scaling
	sbsu_scale u_scale_x (.raw(accel_pend_q[0]),   .scale(accel_scale_q), .scaled(ax));
	sbsu_scale u_scale_y (.raw(accel_pend_q[1]),   .scale(accel_scale_q), .scaled(ay));
	sbsu_scale u_scale_z (.raw(word_s1.data_byte), .scale(accel_scale_q), .scaled(az));

	// sample assembly, unused fields read as zero
	always_comb begin
		result          = '0;
		result.stamp_ms = word_s1.time_ms;
		if (word_s1.kind == KIND_ACCEL) begin
			result.sample_kind = KIND_ACCEL;
			result.accel_x     = ax;
			result.accel_y     = ay;
			result.accel_z     = az;
		end else begin
			result.sample_kind = KIND_OPTICAL;
			if (spo2_mode_q) begin
				result.red_level = {opt_pend_q[0], opt_pend_q[1], opt_pend_q[2]};
				result.ir_level  = {opt_pend_q[3], opt_pend_q[4], word_s1.data_byte};
				result.has_red   = 1'b1;
			end else begin
				result.ir_level  = {opt_pend_q[0], opt_pend_q[1], word_s1.data_byte};
			end
		end
	end

	// fill counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			accel_fill_q <= 2'd0;
			opt_fill_q   <= 3'd0;
		end else if (adv_s1) begin
			if (word_s1.kind == KIND_ACCEL) begin
				accel_fill_q <= accel_done ? 2'd0 : accel_fill_q + 2'd1;
			end else begin
				opt_fill_q <= opt_done ? 3'd0 : opt_fill_q + 3'd1;
			end
		end
	end

	// held bytes, written at the current fill position
	always_ff @(posedge clk) begin
		if (adv_s1 && !produce) begin
			if (word_s1.kind == KIND_ACCEL) begin
				accel_pend_q[accel_fill_q[0]] <= word_s1.data_byte;
			end else begin
				opt_pend_q[opt_fill_q] <= word_s1.data_byte;
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			smp_valid_q <= 1'b0;
		end else if (adv_s1 && produce) begin
			smp_valid_q <= 1'b1;
		end else if (!smp_stall) begin
			smp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && produce) begin
			smp_word_q <= result;
		end
	end

	assign smp_valid = smp_valid_q;
	assign smp_word  = smp_word_q;

	// accel hold count never reaches a full group
	a_accel_fill: assert property (@(posedge clk) disable iff (!arst_n)
		accel_fill_q != 2'd3)
		else $error("accel fill out of range");

	// optical hold count stays within the holding registers
	a_opt_fill: assert property (@(posedge clk) disable iff (!arst_n)
		opt_fill_q <= 3'd5)
		else $error("optical fill out of range");

	// a completing word that moves on always shows a sample next cycle
	a_done_emits: assert property (@(posedge clk) disable iff (!arst_n)
		adv_s1 && produce |=> smp_valid_q && smp_word_q.stamp_ms == $past(word_s1.time_ms))
		else $error("completed group lost");

	// stage 1 is never overwritten while it holds a word that cannot move
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !adv_s1 |=> valid_s1 && $stable(word_s1))
		else $error("stage 1 word overwritten");

endmodule

// ----- verif/sensor_byte_stream_unpacker_tb.sv -----
// self-checking testbench for the sensor byte stream unpacker
module sensor_byte_stream_unpacker_tb
	import sbsu_pkg::*;
;

	// run limit in clock cycles, well above the slowest legal run
	localparam int unsigned CYCLE_LIMIT = 400000;

	// receiver back-pressure patterns
	typedef enum int {RX_FREE, RX_LIGHT, RX_HEAVY, RX_PERIODIC} rx_pattern_t;

	// tracks the group state and the samples still to come out of the block
	class sample_scoreboard;
		logic [15:0] scale;
		logic        spo2;
		logic [7:0]  accel_held [2];
		int          accel_cnt;
		logic [7:0]  opt_held [5];
		int          opt_cnt;
		smp_word_t   due_q [$];
		int          errors;
		int          words_in;

		function new();
			scale     = ACCEL_SCALE_RST;
			spo2      = SPO2_MODE_RST;
			accel_cnt = 0;
			opt_cnt   = 0;
			errors    = 0;
			words_in  = 0;
		endfunction

		function void set_config(logic [15:0] new_scale, logic new_spo2);
			scale = new_scale;
			spo2  = new_spo2;
		endfunction

		// signed 8-bit count times unsigned Q4.12 scale, fits in 24 bits
		function logic [23:0] scaled(logic [7:0] raw);
			int prod;
			prod = int'($signed(raw)) * int'(scale);
			return prod[23:0];
		endfunction

		// one accepted byte word: update the groups, queue a sample if one completes
		function void note_word(src_word_t w);
			smp_word_t s;
			int        group;
			s          = '0;
			s.stamp_ms = w.time_ms;
			words_in++;
			if (w.kind == KIND_ACCEL) begin
				if (accel_cnt + 1 < int'(ACCEL_GROUP)) begin
					accel_held[accel_cnt] = w.data_byte;
					accel_cnt++;
				end else begin
					s.sample_kind = KIND_ACCEL;
					s.accel_x     = scaled(accel_held[0]);
					s.accel_y     = scaled(accel_held[1]);
					s.accel_z     = scaled(w.data_byte);
					accel_cnt     = 0;
					due_q.push_back(s);
				end
			end else begin
				// group size follows the mode at each byte, so a shrink mid-group
				// completes at once and drops the surplus held bytes
				group = spo2 ? int'(OPT_GROUP_SPO2) : int'(OPT_GROUP_IR);
				if (opt_cnt + 1 < group) begin
					opt_held[opt_cnt] = w.data_byte;
					opt_cnt++;
				end else begin
					s.sample_kind = KIND_OPTICAL;
					if (spo2) begin
						s.red_level = {opt_held[0], opt_held[1], opt_held[2]};
						s.ir_level  = {opt_held[3], opt_held[4], w.data_byte};
						s.has_red   = 1'b1;
					end else begin
						s.ir_level = {opt_held[0], opt_held[1], w.data_byte};
					end
					opt_cnt = 0;
					due_q.push_back(s);
				end
			end
		endfunction

		function void cmp(string fld, logic [31:0] want, logic [31:0] got);
			if (want !== got) begin
				errors++;
				$display("%0t: %s expected %h, got %h", $time, fld, want, got);
			end
		endfunction

		function void check_sample(smp_word_t got);
			smp_word_t want;
			if (due_q.size() == 0) begin
				errors++;
				$display("%0t: sample expected none, got %h", $time, got);
				return;
			end
			want = due_q.pop_front();
			cmp("sample_kind", want.sample_kind, got.sample_kind);
			cmp("accel_x", want.accel_x, got.accel_x);
			cmp("accel_y", want.accel_y, got.accel_y);
			cmp("accel_z", want.accel_z, got.accel_z);
			cmp("red_level", want.red_level, got.red_level);
			cmp("ir_level", want.ir_level, got.ir_level);
			cmp("has_red", want.has_red, got.has_red);
			cmp("stamp_ms", want.stamp_ms, got.stamp_ms);
		endfunction
	endclass

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  cfg_we;
	logic [0:0]            cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic                  src_valid;
	logic                  src_stall;
	src_word_t             src_word;
	logic                  smp_valid;
	logic                  smp_stall;
	smp_word_t             smp_word;

	sample_scoreboard sb = new();

	int unsigned cycles = 0;
	int          burst_left = 0;

	sensor_byte_stream_unpacker dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.src_valid (src_valid),
		.src_stall (src_stall),
		.src_word  (src_word),
		.smp_valid (smp_valid),
		.smp_stall (smp_stall),
		.smp_word  (smp_word)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// offer one byte word; the sender runs in bursts with random gaps between
	// them, and the word is held steady until the block takes it
	task automatic offer_byte(input logic k, input logic [7:0] b, input logic [31:0] t);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 32);
			gap = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 24) : $urandom_range(0, 3);
			if (gap > 0) begin
				src_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		src_valid <= 1'b1;
		src_word  <= '{kind: k, data_byte: b, time_ms: t};
		do @(posedge clk); while (src_stall);
		sb.note_word(src_word);
	endtask

	// drain: stop offering, wait for every queued sample, then let stage 1 and
	// the output register empty, since the last byte may have completed nothing
	task automatic settle();
		src_valid  <= 1'b0;
		burst_left = 0;
		while (sb.due_q.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// both registers in back-to-back cycles, write enable held high across them;
	// the mode word carries random upper bits that the block must ignore
	task automatic load_config(input logic [15:0] scale, input logic spo2);
		logic [15:0] mode_word;
		mode_word    = 16'($urandom);
		mode_word[0] = spo2;
		cfg_we    <= 1'b1;
		cfg_index <= REG_ACCEL_SCALE;
		cfg_data  <= scale;
		@(posedge clk);
		cfg_index <= REG_SPO2_MODE;
		cfg_data  <= mode_word;
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.set_config(scale, spo2);
	endtask

	// receiver: stall pattern of its own, plus one long hold-off so the
	// output backs up and the block has to stall its input
	initial begin
		rx_pattern_t pattern;
		int          left;
		int          hold_left;
		bit          held;
		int unsigned rx_cyc;
		pattern   = RX_FREE;
		left      = 0;
		hold_left = 0;
		held      = 1'b0;
		rx_cyc    = 0;
		smp_stall <= 1'b0;
		forever begin
			@(posedge clk);
			rx_cyc++;
			if (hold_left > 0) begin
				hold_left--;
				smp_stall <= 1'b1;
			end else if (!held && sb.words_in >= 150) begin
				held      = 1'b1;
				hold_left = 250;
				smp_stall <= 1'b1;
			end else begin
				if (left == 0) begin
					pattern = rx_pattern_t'($urandom_range(0, 3));
					left    = $urandom_range(20, 200);
				end
				left--;
				case (pattern)
					RX_FREE:     smp_stall <= 1'b0;
					RX_LIGHT:    smp_stall <= ($urandom_range(0, 9) < 3);
					RX_HEAVY:    smp_stall <= ($urandom_range(0, 9) < 8);
					RX_PERIODIC: smp_stall <= (rx_cyc % 5 < 2);
					default:     smp_stall <= 1'b0;
				endcase
			end
		end
	end

	// every sample taken by the receiver goes to the scoreboard
	always @(posedge clk) begin
		if (arst_n && smp_valid && !smp_stall)
			sb.check_sample(smp_word);
	end

	// watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("Mismatches found");
			$finish;
		end
	end

	initial begin
		int          n;
		int          bias;
		int          sel;
		logic        k;
		logic [7:0]  b;
		logic [31:0] t;
		logic [15:0] scale;
		logic        spo2;

		arst_n    <= 1'b0;
		src_valid <= 1'b0;
		src_word  <= '0;
		cfg_we    <= 1'b0;
		cfg_index <= REG_ACCEL_SCALE;
		cfg_data  <= '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset config: scale 4096, spo2 on; streams interleaved so each
		// partial group has to survive bytes of the other stream
		offer_byte(KIND_ACCEL, 8'h80, 32'd0);
		offer_byte(KIND_OPTICAL, 8'hFF, 32'd1);
		offer_byte(KIND_ACCEL, 8'h7F, 32'd2);
		offer_byte(KIND_OPTICAL, 8'h00, 32'd3);
		offer_byte(KIND_ACCEL, 8'hFF, 32'hFFFF_FFFF);
		offer_byte(KIND_OPTICAL, 8'hAB, 32'h8000_0000);
		offer_byte(KIND_OPTICAL, 8'hFF, 32'h7FFF_FFFF);
		offer_byte(KIND_OPTICAL, 8'h01, 32'h0000_0001);
		offer_byte(KIND_OPTICAL, 8'h80, 32'hFFFF_FFFF);
		// leave five optical and two accel bytes held across the config change
		offer_byte(KIND_OPTICAL, 8'h12, 32'd10);
		offer_byte(KIND_OPTICAL, 8'h34, 32'd11);
		offer_byte(KIND_OPTICAL, 8'h56, 32'd12);
		offer_byte(KIND_OPTICAL, 8'h78, 32'd13);
		offer_byte(KIND_OPTICAL, 8'h9A, 32'd14);
		offer_byte(KIND_ACCEL, 8'h80, 32'd15);
		offer_byte(KIND_ACCEL, 8'h7F, 32'd16);
		settle();

		// full scale, infrared only: the next optical byte finishes a group
		// that was five deep, keeping only the first two held bytes
		load_config(16'hFFFF, 1'b0);
		offer_byte(KIND_OPTICAL, 8'hBC, 32'hDEAD_BEEF);
		offer_byte(KIND_ACCEL, 8'hFF, 32'h0123_4567);
		offer_byte(KIND_OPTICAL, 8'hC3, 32'd20);
		offer_byte(KIND_OPTICAL, 8'hD4, 32'd21);
		settle();

		// zero scale, back to red plus infrared with two bytes already held
		load_config(16'h0000, 1'b1);
		offer_byte(KIND_OPTICAL, 8'hE5, 32'd30);
		offer_byte(KIND_OPTICAL, 8'hF6, 32'd31);
		offer_byte(KIND_OPTICAL, 8'h07, 32'd32);
		offer_byte(KIND_OPTICAL, 8'h18, 32'd33);
		settle();

		// random phases, each under its own settings; groups carry over between them
		for (int p = 0; p < 9; p++) begin
			case (p % 5)
				0:       scale = 16'h0000;
				1:       scale = 16'hFFFF;
				2:       scale = ACCEL_SCALE_RST;
				3:       scale = 16'h0001;
				default: scale = 16'($urandom);
			endcase
			spo2 = (p < 2) ? p[0] : 1'($urandom_range(0, 1));
			load_config(scale, spo2);
			bias = $urandom_range(15, 85);
			n = (p == 0) ? 400 : 200;
			repeat (n) begin
				k   = ($urandom_range(0, 99) < bias) ? KIND_OPTICAL : KIND_ACCEL;
				sel = $urandom_range(0, 11);
				case (sel)
					0:       b = 8'h00;
					1:       b = 8'hFF;
					2:       b = 8'h80;
					3:       b = 8'h7F;
					default: b = 8'($urandom);
				endcase
				if ($urandom_range(0, 19) == 0)
					t = ($urandom_range(0, 1) == 1) ? 32'hFFFF_FFFF : 32'h0000_0000;
				else
					t = $urandom;
				offer_byte(k, b, t);
			end
			settle();
		end

		repeat (6) @(posedge clk);
		if (sb.errors == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

// ----- filelist.f -----
hw/rtl/sbsu_pkg.sv
hw/rtl/sbsu_scale.sv
hw/rtl/sensor_byte_stream_unpacker.sv
verif/sensor_byte_stream_unpacker_tb.sv
